// ===== sv/lpd_pkg.sv =====
// Shared constants, command and status types, and the CRC-8 step function of the deframer.
package lpd_pkg;

    // Framing bytes.
    localparam logic [7:0] HDR_BYTE    = 8'h54;
    localparam logic [7:0] TYPE_MEAS   = 8'h2C;
    localparam logic [7:0] TYPE_HEALTH = 8'hE0;
    localparam logic [7:0] TYPE_INFO   = 8'h0F;
    localparam logic [7:0] CRC_POLY    = 8'h4D;

    // Length of a health or info packet, header and type included.
    localparam int SHORT_LEN = 12;

    // Byte offsets inside a measurement packet that do not depend on the point count.
    localparam int OFS_SPEED = 2;
    localparam int OFS_FIRST = 4;
    localparam int OFS_POINT = 6;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic hdr_start;
        logic type_meas;
        logic type_skip;
        logic meas_byte;
        logic skip_byte;
        logic rd_init;
        logic rd_next;
        logic cap_lo;
        logic cap_hi;
        logic cap_str;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_hdr;
        logic is_meas_type;
        logic is_short_type;
        logic meas_last;
        logic skip_done;
        logic crc_ok;
        logic pt_last;
        logic out_free;
    } t_stat;

    // One byte of CRC-8, MSB first, no reflection.
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (v[7]) begin
                v = {v[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                v = {v[6:0], 1'b0};
            end
        end
        return v;
    endfunction

endpackage

// ===== sv/lpd_ctrl.sv =====
// Controller state machine: framing, packet parsing and result sequencing.
module lpd_ctrl
    import lpd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [8:0] {
        S_HUNT = 9'b000000001,
        S_TYPE = 9'b000000010,
        S_MEAS = 9'b000000100,
        S_SKIP = 9'b000001000,
        S_RD0  = 9'b000010000,
        S_RD1  = 9'b000100000,
        S_RD2  = 9'b001000000,
        S_RD3  = 9'b010000000,
        S_OUT  = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   acc;

    // Input beats are taken only while parsing.
    assign o_in_stall = !(r_state == S_HUNT || r_state == S_TYPE ||
                          r_state == S_MEAS || r_state == S_SKIP);
    assign acc = i_in_valid && !o_in_stall;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_HUNT: begin
                if (acc && i_stat.is_hdr) begin
                    o_cmd.hdr_start = 1'b1;
                    n_state         = S_TYPE;
                end
            end
            S_TYPE: begin
                if (acc) begin
                    if (i_stat.is_meas_type) begin
                        o_cmd.type_meas = 1'b1;
                        n_state         = S_MEAS;
                    end else if (i_stat.is_short_type) begin
                        o_cmd.type_skip = 1'b1;
                        n_state         = S_SKIP;
                    end else begin
                        n_state = S_HUNT;
                    end
                end
            end
            S_SKIP: begin
                if (acc) begin
                    o_cmd.skip_byte = 1'b1;
                    if (i_stat.skip_done) begin
                        n_state = S_HUNT;
                    end
                end
            end
            S_MEAS: begin
                if (acc) begin
                    if (i_stat.meas_last) begin
                        if (i_stat.crc_ok) begin
                            o_cmd.rd_init = 1'b1;
                            n_state       = S_RD0;
                        end else begin
                            n_state = S_HUNT;
                        end
                    end else begin
                        o_cmd.meas_byte = 1'b1;
                    end
                end
            end
            S_RD0: begin
                o_cmd.rd_next = 1'b1;
                n_state       = S_RD1;
            end
            S_RD1: begin
                o_cmd.cap_lo  = 1'b1;
                o_cmd.rd_next = 1'b1;
                n_state       = S_RD2;
            end
            S_RD2: begin
                o_cmd.cap_hi  = 1'b1;
                o_cmd.rd_next = 1'b1;
                n_state       = S_RD3;
            end
            S_RD3: begin
                o_cmd.cap_str = 1'b1;
                n_state       = S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = i_stat.pt_last ? S_HUNT : S_RD0;
                end
            end
            default: begin
                n_state = S_HUNT;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_HUNT;
        end else begin
            r_state <= n_state;
        end
    end

    // The final point of a packet returns the parser to the hunt.
    a_last_to_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && i_stat.out_free && i_stat.pt_last) |=> r_state == S_HUNT)
        else $error("last point did not return to hunt");

    // A packet with a good CRC starts the point readout.
    a_good_crc_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && r_state == S_MEAS && i_stat.meas_last && i_stat.crc_ok) |=> r_state == S_RD0)
        else $error("good packet did not start readout");

    // A bad CRC yields no readout.
    a_bad_crc_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && r_state == S_MEAS && i_stat.meas_last && !i_stat.crc_ok) |=> r_state == S_HUNT)
        else $error("bad packet was not dropped");

endmodule

// ===== sv/lpd_dpath.sv =====
// Datapath: byte counter, CRC, packet memory, header fields and output register.
module lpd_dpath
    import lpd_pkg::*;
#(
    parameter int POINTS_PER_PACKET = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_out_stall,
    output logic        o_out_valid,
    output logic [15:0] o_rotation_speed,
    output logic [15:0] o_first_angle,
    output logic [15:0] o_final_angle,
    output logic [15:0] o_time_stamp,
    output logic [3:0]  o_point_number,
    output logic [15:0] o_range_value,
    output logic [7:0]  o_strength,
    output logic        o_last
);

    localparam int PKT_LEN   = 3 * POINTS_PER_PACKET + 11;
    localparam int CNT_W     = $clog2(PKT_LEN);
    localparam int PT_W      = (POINTS_PER_PACKET > 1) ? $clog2(POINTS_PER_PACKET) : 1;
    localparam int OFS_FINAL = 6 + 3 * POINTS_PER_PACKET;
    localparam int OFS_STAMP = 8 + 3 * POINTS_PER_PACKET;

    logic [CNT_W-1:0] r_count;
    logic [7:0]       r_crc;
    logic [7:0]       r_mem [PKT_LEN];
    logic [CNT_W-1:0] r_raddr;
    logic [7:0]       r_rdata;
    logic [PT_W-1:0]  r_pt;
    logic [15:0]      r_speed;
    logic [15:0]      r_first;
    logic [15:0]      r_final;
    logic [15:0]      r_stamp;
    logic [15:0]      r_range;
    logic [7:0]       r_str;
    logic             r_out_valid;
    logic [PT_W+3:0]  pt_ext;

    // Status toward the controller.
    always_comb begin
        o_stat.is_hdr        = (i_rx_byte == HDR_BYTE);
        o_stat.is_meas_type  = (i_rx_byte == TYPE_MEAS);
        o_stat.is_short_type = (i_rx_byte == TYPE_HEALTH) || (i_rx_byte == TYPE_INFO);
        o_stat.meas_last     = (r_count == CNT_W'(PKT_LEN - 1));
        o_stat.skip_done     = (r_count == CNT_W'(SHORT_LEN - 1));
        o_stat.crc_ok        = (r_crc == i_rx_byte);
        o_stat.pt_last       = (r_pt == PT_W'(POINTS_PER_PACKET - 1));
        o_stat.out_free      = !r_out_valid || !i_out_stall;
    end

    // Byte counter and running CRC.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_crc   <= '0;
        end else if (i_cmd.hdr_start) begin
            r_count <= CNT_W'(1);
            r_crc   <= crc8_step(8'h00, i_rx_byte);
        end else if (i_cmd.type_meas) begin
            r_count <= CNT_W'(2);
            r_crc   <= crc8_step(r_crc, i_rx_byte);
        end else if (i_cmd.type_skip) begin
            r_count <= CNT_W'(2);
        end else if (i_cmd.meas_byte) begin
            r_count <= r_count + CNT_W'(1);
            r_crc   <= crc8_step(r_crc, i_rx_byte);
        end else if (i_cmd.skip_byte) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    // Packet memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.meas_byte) begin
            r_mem[r_count] <= i_rx_byte;
        end
        r_rdata <= r_mem[r_raddr];
    end

    // Per-packet fields sit at fixed offsets and are caught as they arrive.
    always_ff @(posedge i_clk) begin
        if (i_cmd.meas_byte) begin
            if (r_count == CNT_W'(OFS_SPEED))     r_speed[7:0]  <= i_rx_byte;
            if (r_count == CNT_W'(OFS_SPEED + 1)) r_speed[15:8] <= i_rx_byte;
            if (r_count == CNT_W'(OFS_FIRST))     r_first[7:0]  <= i_rx_byte;
            if (r_count == CNT_W'(OFS_FIRST + 1)) r_first[15:8] <= i_rx_byte;
            if (r_count == CNT_W'(OFS_FINAL))     r_final[7:0]  <= i_rx_byte;
            if (r_count == CNT_W'(OFS_FINAL + 1)) r_final[15:8] <= i_rx_byte;
            if (r_count == CNT_W'(OFS_STAMP))     r_stamp[7:0]  <= i_rx_byte;
            if (r_count == CNT_W'(OFS_STAMP + 1)) r_stamp[15:8] <= i_rx_byte;
        end
    end

    // Readout address and point index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raddr <= '0;
            r_pt    <= '0;
        end else begin
            if (i_cmd.rd_init) begin
                r_raddr <= CNT_W'(OFS_POINT);
                r_pt    <= '0;
            end else begin
                if (i_cmd.rd_next) begin
                    r_raddr <= r_raddr + CNT_W'(1);
                end
                if (i_cmd.out_load && !o_stat.pt_last) begin
                    r_pt <= r_pt + PT_W'(1);
                end
            end
        end
    end

    // Assembly of one point from three memory reads.
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_lo) begin
            r_range[7:0] <= r_rdata;
        end
        if (i_cmd.cap_hi) begin
            r_range[15:8] <= r_rdata;
        end
        if (i_cmd.cap_str) begin
            r_str <= r_rdata;
        end
    end

    assign pt_ext = {4'b0000, r_pt};

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload, loaded only when the register is free.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_rotation_speed <= r_speed;
            o_first_angle    <= r_first;
            o_final_angle    <= r_final;
            o_time_stamp     <= r_stamp;
            o_point_number   <= pt_ext[3:0];
            o_range_value    <= r_range;
            o_strength       <= r_str;
            o_last           <= o_stat.pt_last;
        end
    end

    assign o_out_valid = r_out_valid;

    // A result is never loaded over one that is still held by the receiver.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || !i_out_stall))
        else $error("output register overwritten while stalled");

    // Body bytes are only written inside the packet.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.meas_byte |-> (r_count < CNT_W'(PKT_LEN - 1)))
        else $error("measurement byte beyond packet length");

    // The point index stays within the packet.
    a_pt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pt <= PT_W'(POINTS_PER_PACKET - 1))
        else $error("point index out of range");

endmodule

// ===== sv/lidar_packet_deframer_crc8_top.sv =====
// Top level of the framed packet deframer with CRC-8 check.
// Input bytes are taken one per cycle while parsing; a packet of 3*P+11 bytes takes that many beats.
// After the last byte of a packet with a good CRC, the first point is read out through S_RD0 to S_RD3 and S_OUT.
// Each further point is assembled from three reads of the packet memory's registered read port in the same way.
// The input is stalled during readout; a bad CRC starts no readout and returns the parser to the header hunt.
// Synchronous active-low reset returns the parser to the header hunt and empties the output.
module lidar_packet_deframer_crc8_top
    import lpd_pkg::*;
#(
    parameter int POINTS_PER_PACKET = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_rotation_speed,
    output logic [15:0] o_first_angle,
    output logic [15:0] o_final_angle,
    output logic [15:0] o_time_stamp,
    output logic [3:0]  o_point_number,
    output logic [15:0] o_range_value,
    output logic [7:0]  o_strength,
    output logic        o_last
);

    t_cmd  cmd;
    t_stat stat;

    // Parsing and sequencing control.
    lpd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Storage, CRC and result assembly.
    lpd_dpath #(
        .POINTS_PER_PACKET (POINTS_PER_PACKET)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_rx_byte        (i_rx_byte),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_rotation_speed (o_rotation_speed),
        .o_first_angle    (o_first_angle),
        .o_final_angle    (o_final_angle),
        .o_time_stamp     (o_time_stamp),
        .o_point_number   (o_point_number),
        .o_range_value    (o_range_value),
        .o_strength       (o_strength),
        .o_last           (o_last)
    );

endmodule
